/* rtl/sspg_pkg.sv */
`default_nettype none

package sspg_pkg;

  localparam int DEF_MAX_CHANNELS = 10;
  localparam int DEF_FRAME_TICKS  = 20000;

  localparam int ACTION_W   = 2;
  localparam int CHANNEL_W  = 4;
  localparam int ANGLE_W    = 8;
  localparam int WIDTH_W    = 16;
  localparam int US_W       = 15;
  localparam int COUNT_W    = 4;
  localparam int SLOT_W     = 4;
  localparam int TICK_W     = 16;
  localparam int SUM_W      = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  localparam logic [WIDTH_W-1:0] RESET_WIDTH       = 16'd1500;
  localparam logic [COUNT_W-1:0] RESET_SERVO_COUNT = 4'd1;
  localparam logic [US_W-1:0]    RESET_MIN_US      = 15'd1000;
  localparam logic [US_W-1:0]    RESET_MAX_US      = 15'd2000;
  localparam logic [ANGLE_W-1:0] ANGLE_FULL        = 8'd180;

  // Division by 180 is a multiplication by floor(2^30 / 180) followed by one correction.
  localparam int              PROD_W      = 23;
  localparam int              RECIP_SHIFT = 30;
  localparam logic [PROD_W-1:0] RECIP     = 23'd5965232;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK  = 2'd0,
    ACT_ANGLE = 2'd1,
    ACT_US    = 2'd2
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SERVO_COUNT = 2'd0,
    REG_MIN_US      = 2'd1,
    REG_MAX_US      = 2'd2
  } reg_index_t;

endpackage

`default_nettype wire

/* rtl/sspg_ram.sv */
`default_nettype none

module sspg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 10,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  output logic [WIDTH-1:0] rdata_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

/* rtl/sequential_servo_pulse_generator.sv */
// Servo pulse generator that drives up to MAX_CHANNELS outputs one after another in a repeating
// frame of FRAME_TICKS one-microsecond ticks, followed by a filler slot when not every channel
// is active. Every input transaction gives exactly one result transaction: a tick returns the
// new pin vector, slot index and frame start flag, and a width write returns the result of the
// last tick again. Ticks are taken one per clock cycle while the skid entry is free and no width
// write is in flight. A width write that takes effect holds off the input until it is through:
// angle scaling uses a multiplier, a reciprocal multiplier and a correction step, after which the
// old width is read from the width RAM and the new width and running slot sums are written back; a
// last stage lets the slot read port see the new width. Ignored writes do not hold off the input.
// All widths read as 1500 after reset through per-channel valid bits, so there is no clearing
// pass. A two-entry output buffer lets the block take a transaction while a result waits.
`default_nettype none

module sequential_servo_pulse_generator #(
  parameter int MAX_CHANNELS = sspg_pkg::DEF_MAX_CHANNELS,
  parameter int FRAME_TICKS  = sspg_pkg::DEF_FRAME_TICKS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_en,
  input  logic [sspg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sspg_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [sspg_pkg::ACTION_W-1:0]    action,
  input  logic [sspg_pkg::CHANNEL_W-1:0]   channel,
  input  logic [sspg_pkg::ANGLE_W-1:0]     angle,
  input  logic [sspg_pkg::WIDTH_W-1:0]     pulse_us,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [MAX_CHANNELS-1:0]          pins,
  output logic [sspg_pkg::SLOT_W-1:0]      active_slot,
  output logic                             frame_start
);

  import sspg_pkg::*;

  localparam int                  AW        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam logic [TICK_W-1:0]   FRAME_LEN = TICK_W'(FRAME_TICKS);
  localparam logic [COUNT_W:0]    N_MAX     = (COUNT_W+1)'(MAX_CHANNELS);

  // Configuration registers.
  logic [COUNT_W-1:0] servo_count;
  logic [US_W-1:0]    min_us;
  logic [US_W-1:0]    max_us;

  always_ff @(posedge clk) begin
    if (rst) begin
      servo_count <= RESET_SERVO_COUNT;
      min_us      <= RESET_MIN_US;
      max_us      <= RESET_MAX_US;
    end else if (cfg_en) begin
      unique case (cfg_index)
        REG_SERVO_COUNT: servo_count <= cfg_data[COUNT_W-1:0];
        REG_MIN_US:      min_us      <= cfg_data[US_W-1:0];
        REG_MAX_US:      max_us      <= cfg_data[US_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake and output buffer signals.
  logic                    in_acc;
  logic                    is_tick;
  logic                    busy;
  logic                    o_valid;
  logic                    s_valid;
  logic [MAX_CHANNELS-1:0] o_pins;
  logic [SLOT_W-1:0]       o_slot;
  logic                    o_start;
  logic [MAX_CHANNELS-1:0] s_pins;
  logic [SLOT_W-1:0]       s_slot;
  logic                    s_start;
  logic                    out_take;

  // Frame state and held result.
  logic [SLOT_W-1:0]       slot_index;
  logic [SLOT_W-1:0]       slot_index_next;
  logic [TICK_W-1:0]       slot_ticks;
  logic [TICK_W-1:0]       slot_ticks_next;
  logic [MAX_CHANNELS-1:0] held_pins;
  logic [SLOT_W-1:0]       held_slot;
  logic                    held_start;

  // Width store side state.
  logic [MAX_CHANNELS-1:0] wvalid;
  logic [MAX_CHANNELS-1:0] nz;
  logic [SUM_W-1:0]        sums [MAX_CHANNELS];
  logic [WIDTH_W-1:0]      rda_data;
  logic [WIDTH_W-1:0]      rdb_data;
  logic                    rda_vld;

  // Write pipeline.
  logic                    wr_ok;
  logic [ANGLE_W-1:0]      angle_sat;
  logic [PROD_W-1:0]       prod_in;
  logic                    s1_v, s2_v, s3_v, s4_v, s5_v;
  logic [AW-1:0]           s1_ch, s2_ch, s3_ch, s4_ch;
  logic                    s1_angle, s2_angle;
  logic [PROD_W-1:0]       s1_prod, s2_prod;
  logic [US_W-1:0]         s1_base, s2_base;
  logic [WIDTH_W-1:0]      s1_us, s2_us;
  logic [US_W-1:0]         s2_q0;
  logic [WIDTH_W-1:0]      s3_val, s4_val;
  logic [2*PROD_W-1:0]     recip_prod;
  logic [PROD_W-1:0]       rem;
  logic [US_W-1:0]         quot;
  logic [WIDTH_W-1:0]      angle_width;
  logic [WIDTH_W-1:0]      old_width;
  logic [SUM_W-1:0]        delta;

  // Tick evaluation.
  logic [COUNT_W-1:0]      cnt;
  logic [COUNT_W:0]        n_slots;
  logic                    cnt_lt_max;
  logic [SUM_W-1:0]        width_sum;
  logic                    fill_nz;
  logic [TICK_W-1:0]       flen;
  logic [MAX_CHANNELS-1:0] znz;
  logic                    restart;
  logic [SLOT_W-1:0]       si0;
  logic [TICK_W-1:0]       st0;
  logic                    cur_nz;
  logic [WIDTH_W-1:0]      width_a;
  logic [TICK_W-1:0]       len_cur;
  logic                    stay;
  logic                    found_up;
  logic                    found_lo;
  logic [SLOT_W-1:0]       si_up;
  logic [SLOT_W-1:0]       si_lo;
  logic [SLOT_W-1:0]       si_f;
  logic [TICK_W-1:0]       st_f;
  logic                    pin_on;
  logic [MAX_CHANNELS-1:0] tick_pins;
  logic                    tick_start;
  logic [MAX_CHANNELS-1:0] r_pins;
  logic [SLOT_W-1:0]       r_slot;
  logic                    r_start;

  assign busy     = s1_v | s2_v | s3_v | s4_v | s5_v;
  assign in_stall = busy | s_valid;
  assign in_acc   = in_valid & ~in_stall;
  assign is_tick  = (action == ACT_TICK);

  // Active channel count and slot count of the frame.
  always_comb begin
    if (servo_count == '0) begin
      cnt = COUNT_W'(1);
    end else if ({1'b0, servo_count} > N_MAX) begin
      cnt = N_MAX[COUNT_W-1:0];
    end else begin
      cnt = servo_count;
    end
    cnt_lt_max = ({1'b0, cnt} < N_MAX);
    n_slots    = {1'b0, cnt} + {{COUNT_W{1'b0}}, cnt_lt_max};
  end

  always_comb begin
    width_sum = '0;
    for (int k = 0; k < MAX_CHANNELS; k++) begin
      if ((COUNT_W+1)'(k + 1) == {1'b0, cnt}) begin
        width_sum = sums[k];
      end
    end
    fill_nz = (width_sum < SUM_W'(FRAME_LEN));
    flen    = fill_nz ? (FRAME_LEN - width_sum[TICK_W-1:0]) : '0;
  end

  always_comb begin
    for (int k = 0; k < MAX_CHANNELS; k++) begin
      if ((COUNT_W+1)'(k) < {1'b0, cnt}) begin
        znz[k] = nz[k];
      end else if ((COUNT_W+1)'(k) == {1'b0, cnt}) begin
        znz[k] = fill_nz;
      end else begin
        znz[k] = 1'b0;
      end
    end
  end

  always_comb begin
    restart = ({1'b0, slot_index} >= n_slots);
    si0     = restart ? '0 : slot_index;
    st0     = restart ? '0 : slot_ticks;
    cur_nz  = 1'b0;
    for (int k = 0; k < MAX_CHANNELS; k++) begin
      if (SLOT_W'(k) == si0) begin
        cur_nz = znz[k];
      end
    end
    width_a = rda_vld ? rda_data : RESET_WIDTH;
    len_cur = ({1'b0, si0} < {1'b0, cnt}) ? width_a : flen;
    stay    = (st0 == '0) ? cur_nz : (st0 < len_cur);
  end

  // Next slot with a non-zero length, searched above the current slot and then from zero.
  always_comb begin
    found_up = 1'b0;
    found_lo = 1'b0;
    si_up    = '0;
    si_lo    = '0;
    for (int k = MAX_CHANNELS - 1; k >= 0; k--) begin
      if (znz[k] && (SLOT_W'(k) > si0)) begin
        found_up = 1'b1;
        si_up    = SLOT_W'(k);
      end
      if (znz[k] && (SLOT_W'(k) <= si0)) begin
        found_lo = 1'b1;
        si_lo    = SLOT_W'(k);
      end
    end
  end

  always_comb begin
    priority if (stay) begin
      si_f = si0;
    end else if (found_up) begin
      si_f = si_up;
    end else if (found_lo) begin
      si_f = si_lo;
    end else begin
      si_f = si0;
    end
    st_f       = stay ? st0 : '0;
    pin_on     = (stay | found_up | found_lo) & ({1'b0, si_f} < {1'b0, cnt});
    tick_start = (si_f == '0) && (st_f == '0);
    for (int k = 0; k < MAX_CHANNELS; k++) begin
      tick_pins[k] = pin_on && (si_f == SLOT_W'(k));
    end
  end

  always_comb begin
    if (in_acc && is_tick) begin
      slot_index_next = si_f;
      slot_ticks_next = st_f + TICK_W'(1);
    end else begin
      slot_index_next = slot_index;
      slot_ticks_next = slot_ticks;
    end
  end

  assign r_pins  = is_tick ? tick_pins  : held_pins;
  assign r_slot  = is_tick ? si_f       : held_slot;
  assign r_start = is_tick ? tick_start : held_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_index <= '0;
      slot_ticks <= '0;
      held_pins  <= '0;
      held_slot  <= '0;
      held_start <= 1'b0;
      rda_vld    <= 1'b0;
    end else begin
      slot_index <= slot_index_next;
      slot_ticks <= slot_ticks_next;
      rda_vld    <= wvalid[slot_index_next[AW-1:0]];
      if (in_acc && is_tick) begin
        held_pins  <= tick_pins;
        held_slot  <= si_f;
        held_start <= tick_start;
      end
    end
  end

  // Output register with one skid entry behind it.
  assign out_take    = o_valid & ~out_stall;
  assign out_valid   = o_valid;
  assign pins        = o_pins;
  assign active_slot = o_slot;
  assign frame_start = o_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      s_valid <= 1'b0;
    end else begin
      if (!o_valid || out_take) begin
        o_valid <= s_valid | in_acc;
        s_valid <= s_valid & in_acc;
      end else if (in_acc) begin
        s_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!o_valid || out_take) begin
      if (s_valid) begin
        o_pins  <= s_pins;
        o_slot  <= s_slot;
        o_start <= s_start;
        s_pins  <= r_pins;
        s_slot  <= r_slot;
        s_start <= r_start;
      end else begin
        o_pins  <= r_pins;
        o_slot  <= r_slot;
        o_start <= r_start;
      end
    end else if (in_acc) begin
      s_pins  <= r_pins;
      s_slot  <= r_slot;
      s_start <= r_start;
    end
  end

  // Width writes: scale, divide by 180, then read the old width and write back.
  assign angle_sat = (angle > ANGLE_FULL) ? ANGLE_FULL : angle;
  assign prod_in   = PROD_W'(max_us - min_us) * PROD_W'(angle_sat);
  assign wr_ok     = in_acc && ({1'b0, channel} < N_MAX) &&
                     ((action == ACT_US) || ((action == ACT_ANGLE) && (min_us <= max_us)));

  assign recip_prod  = (2*PROD_W)'(s1_prod) * (2*PROD_W)'(RECIP);
  assign rem         = s2_prod - PROD_W'(s2_q0 * ANGLE_FULL);
  assign quot        = s2_q0 + US_W'(rem >= PROD_W'(ANGLE_FULL));
  assign angle_width = {1'b0, s2_base} + {1'b0, quot};
  assign old_width   = wvalid[s4_ch] ? rdb_data : RESET_WIDTH;
  assign delta       = SUM_W'(s4_val) - SUM_W'(old_width);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
      s5_v <= 1'b0;
    end else begin
      s1_v <= wr_ok;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
      s5_v <= s4_v;
    end
  end

  always_ff @(posedge clk) begin
    s1_ch    <= channel[AW-1:0];
    s1_angle <= (action == ACT_ANGLE);
    s1_prod  <= prod_in;
    s1_base  <= min_us;
    s1_us    <= pulse_us;
    s2_ch    <= s1_ch;
    s2_angle <= s1_angle;
    s2_prod  <= s1_prod;
    s2_base  <= s1_base;
    s2_us    <= s1_us;
    s2_q0    <= recip_prod[RECIP_SHIFT +: US_W];
    s3_ch    <= s2_ch;
    s3_val   <= s2_angle ? angle_width : s2_us;
    s4_ch    <= s3_ch;
    s4_val   <= s3_val;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wvalid <= '0;
      nz     <= '1;
      for (int k = 0; k < MAX_CHANNELS; k++) begin
        sums[k] <= SUM_W'((k + 1) * RESET_WIDTH);
      end
    end else if (s4_v) begin
      wvalid[s4_ch] <= 1'b1;
      nz[s4_ch]     <= (s4_val != '0);
      for (int k = 0; k < MAX_CHANNELS; k++) begin
        if (AW'(k) >= s4_ch) begin
          sums[k] <= sums[k] + delta;
        end
      end
    end
  end

  sspg_ram #(
    .WIDTH (WIDTH_W),
    .DEPTH (MAX_CHANNELS),
    .AW    (AW)
  ) u_width_ram (
    .clk     (clk),
    .we      (s4_v),
    .waddr   (s4_ch),
    .wdata   (s4_val),
    .raddr_a (slot_index_next[AW-1:0]),
    .rdata_a (rda_data),
    .raddr_b (s3_ch),
    .rdata_b (rdb_data)
  );

  assert property (@(posedge clk) disable iff (rst)
    $onehot0({s1_v, s2_v, s3_v, s4_v, s5_v}))
    else $error("Width write pipeline holds more than one transaction.");

  assert property (@(posedge clk) disable iff (rst) s1_v |-> ##3 s4_v)
    else $error("Width write did not reach the write-back stage.");

  assert property (@(posedge clk) disable iff (rst) s_valid |-> o_valid)
    else $error("Skid entry is full while the output register is empty.");

  assert property (@(posedge clk) disable iff (rst) {1'b0, slot_index} < N_MAX)
    else $error("Slot index lies beyond the last channel.");

  assert property (@(posedge clk) disable iff (rst) o_valid |-> $onehot0(o_pins))
    else $error("More than one servo pin is high.");

  assert property (@(posedge clk) disable iff (rst) (o_valid && o_start) |-> (o_slot == '0))
    else $error("Frame start is flagged outside slot zero.");

endmodule

`default_nettype wire

/* tb/servo_frame_checker.sv */
module servo_frame_checker (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_en,
  input  logic [sspg_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [sspg_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  logic                                    in_valid,
  input  logic                                    in_stall,
  input  logic [sspg_pkg::ACTION_W-1:0]           action,
  input  logic [sspg_pkg::CHANNEL_W-1:0]          channel,
  input  logic [sspg_pkg::ANGLE_W-1:0]            angle,
  input  logic [sspg_pkg::WIDTH_W-1:0]            pulse_us,
  input  logic                                    out_valid,
  input  logic                                    out_stall,
  input  logic [sspg_pkg::DEF_MAX_CHANNELS-1:0]   pins,
  input  logic [sspg_pkg::SLOT_W-1:0]             active_slot,
  input  logic                                    frame_start,
  output int                                      pending,
  output int                                      errors
);
  timeunit 1ns;
  timeprecision 1ps;

  import sspg_pkg::*;

  localparam int NCH   = DEF_MAX_CHANNELS;
  localparam int FRAME = DEF_FRAME_TICKS;

  typedef struct packed {
    logic [NCH-1:0]    pins;
    logic [SLOT_W-1:0] slot;
    logic              start;
  } frame_out_t;

  logic [COUNT_W-1:0] servo_cnt;
  logic [US_W-1:0]    min_w;
  logic [US_W-1:0]    max_w;
  logic [WIDTH_W-1:0] widths [NCH];
  logic [SUM_W-1:0]   width_total;
  int unsigned        slot_idx;
  logic [TICK_W-1:0]  slot_ticks;
  frame_out_t         last_out;
  frame_out_t         frame_outputs_q [$];
  int                 fail_cnt = 0;

  function automatic int unsigned live_channels();
    int unsigned c;
    c = servo_cnt;
    if (c == 0) c = 1;
    if (c > NCH) c = NCH;
    return c;
  endfunction

  function automatic void sum_widths();
    int unsigned c;
    int unsigned s;
    c = live_channels();
    s = 0;
    for (int i = 0; i < c; i++) s += widths[i];
    width_total = SUM_W'(s);
  endfunction

  function automatic int unsigned slot_span(int unsigned slot, int unsigned c);
    if (slot < c) return widths[slot];
    if (width_total >= FRAME) return 0;
    return FRAME - width_total;
  endfunction

  always @(posedge clk) begin : track
    int unsigned c;
    int unsigned n;
    int unsigned a;
    logic [NCH-1:0] lit;
    frame_out_t want;
    if (rst) begin
      servo_cnt = RESET_SERVO_COUNT;
      min_w = RESET_MIN_US;
      max_w = RESET_MAX_US;
      for (int i = 0; i < NCH; i++) widths[i] = RESET_WIDTH;
      sum_widths();
      slot_idx = 0;
      slot_ticks = '0;
      last_out = '0;
      frame_outputs_q.delete();
    end else begin
      if (cfg_en) begin
        unique case (cfg_index)
          REG_SERVO_COUNT: begin
            servo_cnt = cfg_data[COUNT_W-1:0];
            sum_widths();
          end
          REG_MIN_US: min_w = cfg_data[US_W-1:0];
          REG_MAX_US: max_w = cfg_data[US_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (action == ACT_TICK) begin
          c = live_channels();
          n = c + ((c < NCH) ? 1 : 0);
          if (slot_idx >= n) begin
            slot_idx = 0;
            slot_ticks = '0;
          end
          // Slots that are already used up are skipped within the same tick.
          for (int k = 0; k < n; k++) begin
            if (slot_ticks < slot_span(slot_idx, c)) break;
            slot_idx = (slot_idx + 1 == n) ? 0 : slot_idx + 1;
            slot_ticks = '0;
          end
          lit = '0;
          if (slot_idx < c && slot_ticks < slot_span(slot_idx, c)) lit[slot_idx] = 1'b1;
          last_out.pins = lit;
          last_out.slot = SLOT_W'(slot_idx);
          last_out.start = (slot_idx == 0 && slot_ticks == 0);
          slot_ticks = slot_ticks + 1'b1;
        end else if ((action == ACT_US || action == ACT_ANGLE) && channel < NCH) begin
          if (action == ACT_US) begin
            widths[channel] = pulse_us;
            sum_widths();
          end else if (min_w <= max_w) begin
            a = (angle > ANGLE_FULL) ? ANGLE_FULL : angle;
            widths[channel] = WIDTH_W'(min_w + ((max_w - min_w) * a) / ANGLE_FULL);
            sum_widths();
          end
        end
        frame_outputs_q.push_back(last_out);
      end
      if (out_valid && !out_stall) begin
        if (frame_outputs_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("%0t: result transaction with nothing outstanding: pins %h slot %0d start %0b",
                     $realtime, pins, active_slot, frame_start);
        end else begin
          want = frame_outputs_q.pop_front();
          if (pins !== want.pins || active_slot !== want.slot || frame_start !== want.start) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("%0t: expected pins %h slot %0d start %0b, got pins %h slot %0d start %0b",
                       $realtime, want.pins, want.slot, want.start,
                       pins, active_slot, frame_start);
          end
        end
      end
    end
    pending <= frame_outputs_q.size();
    errors <= fail_cnt;
  end

endmodule

/* tb/tb_sequential_servo_pulse_generator.sv */
module tb_sequential_servo_pulse_generator;
  timeunit 1ns;
  timeprecision 1ps;

  import sspg_pkg::*;

  localparam int NCH            = DEF_MAX_CHANNELS;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int HOLD_CYCLES    = 400;
  localparam logic [ACTION_W-1:0]  ACT_NONE  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_en;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_stall;
  logic [ACTION_W-1:0]    action;
  logic [CHANNEL_W-1:0]   channel;
  logic [ANGLE_W-1:0]     angle;
  logic [WIDTH_W-1:0]     pulse_us;
  logic                   out_valid;
  logic                   out_stall;
  logic [NCH-1:0]         pins;
  logic [SLOT_W-1:0]      active_slot;
  logic                   frame_start;
  int                     pending;
  int                     errors;

  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned cur_count = 1;
  int unsigned cycle_cnt = 0;

  sequential_servo_pulse_generator i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_en      (cfg_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .channel     (channel),
    .angle       (angle),
    .pulse_us    (pulse_us),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pins        (pins),
    .active_slot (active_slot),
    .frame_start (frame_start)
  );

  servo_frame_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_en      (cfg_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .channel     (channel),
    .angle       (angle),
    .pulse_us    (pulse_us),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pins        (pins),
    .active_slot (active_slot),
    .frame_start (frame_start),
    .pending     (pending),
    .errors      (errors)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: random stall bursts, plus one long hold-off requested by the stimulus.
  initial begin : result_side
    int unsigned burst;
    int unsigned hold_left;
    bit          hold_done;
    burst = 0;
    hold_left = 0;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (burst > 0) begin
        burst--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(0, 10);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Called just after a rising edge; returns at the edge where the transaction is taken.
  task automatic offer(logic [ACTION_W-1:0] act, logic [CHANNEL_W-1:0] ch,
                       logic [ANGLE_W-1:0] ang, logic [WIDTH_W-1:0] pu);
    int unsigned gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 11);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    channel  <= ch;
    angle    <= ang;
    pulse_us <= pu;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic tick();
    offer(ACT_TICK, CHANNEL_W'($urandom_range(0, 15)), ANGLE_W'($urandom_range(0, 255)),
          WIDTH_W'($urandom_range(0, 65535)));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_en    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic configure(int unsigned cnt, int unsigned lo, int unsigned hi, bit stray);
    put_reg(REG_SERVO_COUNT, CFG_DATA_W'(($urandom_range(0, 2047) << COUNT_W) | cnt));
    put_reg(REG_MIN_US, CFG_DATA_W'(lo));
    put_reg(REG_MAX_US, CFG_DATA_W'(hi));
    if (stray) put_reg(REG_SPARE, CFG_DATA_W'($urandom_range(0, 32767)));
    cfg_en <= 1'b0;
    cur_count = (cnt == 0) ? 1 : (cnt > NCH) ? NCH : cnt;
  endtask

  task automatic send_random(int unsigned count);
    int unsigned done;
    int unsigned r;
    int unsigned sel;
    logic [CHANNEL_W-1:0] ch;
    logic [WIDTH_W-1:0] pu;
    logic [ANGLE_W-1:0] ang;
    done = 0;
    while (done < count) begin
      r = $urandom_range(0, 99);
      ch = ($urandom_range(0, 4) != 0) ? CHANNEL_W'($urandom_range(0, cur_count - 1))
                                       : CHANNEL_W'($urandom_range(0, 9));
      if (r < 55) begin
        tick();
        done++;
      end else if (r < 72) begin
        sel = $urandom_range(0, 99);
        if (sel < 50) pu = WIDTH_W'($urandom_range(0, 15));
        else if (sel < 70) pu = WIDTH_W'($urandom_range(16, 300));
        else if (sel < 85) pu = WIDTH_W'($urandom_range(20000, 65535));
        else pu = WIDTH_W'($urandom_range(0, 65535));
        offer(ACT_US, ch, ANGLE_W'($urandom_range(0, 255)), pu);
        done++;
      end else if (r < 94) begin
        if ($urandom_range(0, 3) == 0) ang = $urandom_range(0, 1) ? ANGLE_FULL : '0;
        else ang = ANGLE_W'($urandom_range(0, 255));
        offer(ACT_ANGLE, ch, ang, WIDTH_W'($urandom_range(0, 65535)));
        done++;
      end else if (r < 97) begin
        offer(ACT_NONE, CHANNEL_W'($urandom_range(0, 15)), ANGLE_W'($urandom_range(0, 255)),
              WIDTH_W'($urandom_range(0, 65535)));
      end else begin
        offer($urandom_range(0, 1) ? ACT_US : ACT_ANGLE, CHANNEL_W'($urandom_range(NCH, 15)),
              ANGLE_W'($urandom_range(0, 255)), WIDTH_W'($urandom_range(0, 65535)));
      end
    end
  endtask

  initial begin : stimulus
    int unsigned cnt;
    int unsigned lo;
    int unsigned hi;
    rst       <= 1'b1;
    cfg_en    <= 1'b0;
    cfg_index <= REG_SERVO_COUNT;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    action    <= ACT_TICK;
    channel   <= '0;
    angle     <= '0;
    pulse_us  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    offer(ACT_TICK, '0, '0, '0);
    offer(ACT_TICK, 4'hF, 8'hFF, 16'hFFFF);
    offer(ACT_ANGLE, 4'd0, 8'd0, 16'h0000);
    tick();
    offer(ACT_ANGLE, 4'd0, ANGLE_FULL, 16'hFFFF);
    offer(ACT_ANGLE, 4'd0, 8'hFF, 16'h1234);
    offer(ACT_ANGLE, 4'd3, 8'd90, 16'h0000);
    offer(ACT_US, 4'd0, 8'h00, 16'd0);
    tick();
    tick();
    offer(ACT_US, 4'd0, 8'hAA, 16'hFFFF);
    tick();
    offer(ACT_US, 4'd9, 8'h55, 16'h5555);
    offer(ACT_US, 4'd10, 8'h00, 16'd7);
    offer(ACT_ANGLE, 4'd15, 8'd45, 16'hAAAA);
    offer(ACT_NONE, 4'd2, 8'd10, 16'd100);
    offer(ACT_US, 4'd0, 8'h00, 16'd2);
    repeat (3) tick();
    send_random(ITEMS_PER_PHASE);

    // All ten channels active with zero widths gives a frame of no length at all.
    settle();
    configure(10, 0, 32767, 1'b0);
    for (int i = 0; i < NCH; i++) offer(ACT_US, CHANNEL_W'(i), 8'h00, 16'd0);
    repeat (3) tick();
    send_random(ITEMS_PER_PHASE);

    settle();
    configure(0, 32767, 32767, 1'b1);
    send_random(ITEMS_PER_PHASE);

    settle();
    configure(15, 2000, 1000, 1'b0);
    send_random(ITEMS_PER_PHASE);

    settle();
    configure(1, 0, 0, 1'b0);
    send_random(ITEMS_PER_PHASE);

    settle();
    configure(5, 3, 12, 1'b0);
    hold_req = 1'b1;
    send_random(ITEMS_PER_PHASE);

    for (int p = 0; p < 5; p++) begin
      settle();
      cnt = $urandom_range(0, 15);
      if ($urandom_range(0, 2) == 0) begin
        lo = $urandom_range(0, 32767);
        hi = $urandom_range(0, 32767);
      end else begin
        lo = $urandom_range(0, 40);
        hi = $urandom_range(0, 60);
      end
      configure(cnt, lo, hi, 1'b0);
      send_random(ITEMS_PER_PHASE);
    end

    settle();
    quiet = 1'b1;
    configure(10, 1, 9, 1'b0);
    send_random(ITEMS_PER_PHASE);

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (10) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* sequential_servo_pulse_generator.f */
rtl/sspg_pkg.sv
rtl/sspg_ram.sv
rtl/sequential_servo_pulse_generator.sv
tb/servo_frame_checker.sv
tb/tb_sequential_servo_pulse_generator.sv
